>>> rtl/core/mcr_pkg.sv
package mcr_pkg;

  localparam int COORD_BITS = 11;
  localparam int OUT_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 5;
  localparam int COLOR_BITS = 24;
  localparam int PIX_BITS   = 3;
  localparam int PC_BITS    = 4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic [PC_BITS-1:0] ST_WAIT     = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] ST_DISPATCH = PC_BITS'(1);
  localparam logic [PC_BITS-1:0] ST_INC_X    = PC_BITS'(2);
  localparam logic [PC_BITS-1:0] ST_DEC_Y    = PC_BITS'(3);
  localparam logic [PC_BITS-1:0] ST_ADD_D    = PC_BITS'(4);
  localparam logic [PC_BITS-1:0] ST_EMIT0    = PC_BITS'(5);
  localparam logic [PC_BITS-1:0] ST_EMIT7    = PC_BITS'(12);

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_NOP,
    OP_INC_X,
    OP_DEC_Y,
    OP_ADD_D,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_WORK,
    COND_START
  } cond_t;

  typedef struct packed {
    op_t                 op;
    logic [PIX_BITS-1:0] pix;
    cond_t               cond;
    logic [PC_BITS-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic hold;
    logic no_work;
    logic start;
  } status_t;

  function automatic ucode_t ucode_word(logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '{op: OP_WAIT, pix: '0, cond: COND_ALWAYS, target: ST_WAIT};
    if (pc >= ST_EMIT0 && pc <= ST_EMIT7) begin
      w.op     = OP_EMIT;
      w.pix    = PIX_BITS'(pc - ST_EMIT0);
      w.cond   = (pc == ST_EMIT7) ? COND_ALWAYS : COND_NEVER;
      w.target = ST_WAIT;
    end else begin
      unique case (pc)
        ST_WAIT:     w = '{op: OP_WAIT, pix: '0, cond: COND_NO_WORK, target: ST_WAIT};
        ST_DISPATCH: w = '{op: OP_NOP, pix: '0, cond: COND_START, target: ST_EMIT0};
        ST_INC_X:    w = '{op: OP_INC_X, pix: '0, cond: COND_NEVER, target: ST_WAIT};
        ST_DEC_Y:    w = '{op: OP_DEC_Y, pix: '0, cond: COND_NEVER, target: ST_WAIT};
        ST_ADD_D:    w = '{op: OP_ADD_D, pix: '0, cond: COND_NEVER, target: ST_WAIT};
        default:     w = '{op: OP_WAIT, pix: '0, cond: COND_ALWAYS, target: ST_WAIT};
      endcase
    end
    return w;
  endfunction

endpackage

>>> rtl/core/mcr_if.sv
interface mcr_req_if import mcr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius;
  logic [COLOR_BITS-1:0] pixel_color;

  modport source (output valid, req_type, center_x, center_y, radius, pixel_color,
                  input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, pixel_color,
                  output ready);
endinterface

interface mcr_pix_if import mcr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] out_x;
  logic signed [OUT_BITS-1:0] out_y;
  logic [COLOR_BITS-1:0]      out_color;
  logic                       last_of_set;
  logic                       circle_done;

  modport source (output valid, out_x, out_y, out_color, last_of_set, circle_done,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_color, last_of_set, circle_done,
                  output ready);
endinterface

>>> rtl/core/mcr_sequencer.sv
module mcr_sequencer import mcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output ucode_t  ctl
);

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic               jump;

  always_comb begin
    ctl = ucode_word(pc);
    unique case (ctl.cond)
      COND_NEVER:   jump = 1'b0;
      COND_ALWAYS:  jump = 1'b1;
      COND_NO_WORK: jump = stat.no_work;
      COND_START:   jump = stat.start;
      default:      jump = 1'b0;
    endcase
    if (stat.hold) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + PC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/core/mcr_datapath.sv
module mcr_datapath import mcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ucode_t            ctl,
  output status_t           stat,
  mcr_req_if.sink           req,
  mcr_pix_if.source         pix
);

  logic                       active;
  logic                       start_q;
  logic                       done_q;
  logic [COORD_BITS-1:0]      centre_col;
  logic [COORD_BITS-1:0]      centre_row;
  logic [COLOR_BITS-1:0]      draw_color;
  logic signed [OUT_BITS-1:0] col_offset;
  logic signed [OUT_BITS-1:0] row_offset;
  logic signed [DEC_BITS-1:0] decision;

  logic                       accept;
  logic                       out_load;
  logic                       d_pos;
  logic signed [OUT_BITS-1:0] diff;
  logic signed [DEC_BITS-1:0] inc_big;
  logic signed [DEC_BITS-1:0] inc_small;
  logic signed [OUT_BITS-1:0] cx;
  logic signed [OUT_BITS-1:0] cy;
  logic signed [OUT_BITS-1:0] off_a;
  logic signed [OUT_BITS-1:0] off_b;
  logic signed [OUT_BITS-1:0] px;
  logic signed [OUT_BITS-1:0] py;

  always_comb begin
    req.ready    = (ctl.op == OP_WAIT);
    accept       = req.valid && req.ready;
    out_load     = (ctl.op == OP_EMIT) && (!pix.valid || pix.ready);
    stat.hold    = (ctl.op == OP_EMIT) && !out_load;
    stat.no_work = !accept || (req.req_type == REQ_STEP && !active);
    stat.start   = start_q;

    d_pos     = decision > 0;
    diff      = col_offset - row_offset;
    inc_big   = (DEC_BITS'(diff) <<< 2) + DEC_BITS'(10);
    inc_small = (DEC_BITS'(col_offset) <<< 2) + DEC_BITS'(6);

    // octant swap on the upper half of the set, sign flips from the low bits
    cx    = OUT_BITS'(centre_col);
    cy    = OUT_BITS'(centre_row);
    off_a = ctl.pix[2] ? row_offset : col_offset;
    off_b = ctl.pix[2] ? col_offset : row_offset;
    px    = ctl.pix[0] ? cx - off_a : cx + off_a;
    py    = ctl.pix[1] ? cy - off_b : cy + off_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      start_q   <= 1'b0;
      done_q    <= 1'b0;
      pix.valid <= 1'b0;
    end else begin
      if (accept) begin
        start_q <= (req.req_type == REQ_START);
        if (req.req_type == REQ_START) begin
          active <= 1'b1;
          done_q <= 1'b0;
        end
      end
      if (ctl.op == OP_ADD_D) begin
        done_q <= row_offset < col_offset;
        if (row_offset < col_offset) begin
          active <= 1'b0;
        end
      end
      if (out_load) begin
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_START) begin
      centre_col <= req.center_x;
      centre_row <= req.center_y;
      draw_color <= req.pixel_color;
      col_offset <= '0;
      row_offset <= OUT_BITS'(req.radius);
      decision   <= DEC_BITS'(3) - (DEC_BITS'(req.radius) << 1);
    end else begin
      unique case (ctl.op)
        OP_INC_X: col_offset <= col_offset + OUT_BITS'(1);
        OP_DEC_Y: begin
          if (d_pos) begin
            row_offset <= row_offset - OUT_BITS'(1);
          end
        end
        OP_ADD_D: decision <= decision + (d_pos ? inc_big : inc_small);
        OP_WAIT, OP_NOP, OP_EMIT: ;
        default: ;
      endcase
    end
    if (out_load) begin
      pix.out_x       <= px;
      pix.out_y       <= py;
      pix.out_color   <= draw_color;
      pix.last_of_set <= (ctl.pix == '1);
      pix.circle_done <= (ctl.pix == '1) && done_q;
    end
  end

endmodule

>>> rtl/core/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer. A start transaction latches centre, radius and color and
// yields the eight symmetric pixels of the first point; each step transaction advances
// the point and yields its eight pixels, the last one flagged, with circle_done on the
// final set. A step while no circle is active is taken and yields nothing. Items are
// taken one at a time: a start runs wait, dispatch and eight emit steps, a step runs wait,
// dispatch, three serial update steps of the datapath and eight emit steps, and an emit
// step waits while the pixel output is held by backpressure; the rate is set by the
// microcode sequence and the single pixel-per-cycle output register.
module midpoint_circle_rasterizer_unit import mcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mcr_req_if.sink   req,
  mcr_pix_if.source pix
);

  ucode_t  ctl;
  status_t stat;

  mcr_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  mcr_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat),
    .req  (req),
    .pix  (pix)
  );

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.circle_done |-> pix.last_of_set)
    else $error("circle_done without last_of_set");

  a_start_leaves_wait: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.req_type == REQ_START |=> !req.ready)
    else $error("sequencer still waiting after start transaction");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_EMIT && pix.valid && !pix.ready |=> $stable(ctl.pix))
    else $error("pixel index moved while output stalled");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
  import mcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 470;
  localparam int SETTLE       = 32;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] r;
    logic [COLOR_BITS-1:0] color;
  } request_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic [COLOR_BITS-1:0]      color;
    logic                       last;
    logic                       done;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t                     expected_pixels[$];
    int                         errors = 0;
    logic                       active = 1'b0;
    logic signed [OUT_BITS-1:0] col_off = '0;
    logic signed [OUT_BITS-1:0] row_off = '0;
    logic signed [DEC_BITS-1:0] decision = '0;
    logic [COORD_BITS-1:0]      centre_col = '0;
    logic [COORD_BITS-1:0]      centre_row = '0;
    logic [COLOR_BITS-1:0]      draw_color = '0;

    function void push_set(logic done);
      logic signed [OUT_BITS-1:0] xc;
      logic signed [OUT_BITS-1:0] yc;
      logic signed [OUT_BITS-1:0] px[8];
      logic signed [OUT_BITS-1:0] py[8];
      pixel_t                     p;
      xc = signed'({2'b00, centre_col});
      yc = signed'({2'b00, centre_row});
      px = '{xc + col_off, xc - col_off, xc + col_off, xc - col_off,
             xc + row_off, xc - row_off, xc + row_off, xc - row_off};
      py = '{yc + row_off, yc + row_off, yc - row_off, yc - row_off,
             yc + col_off, yc + col_off, yc - col_off, yc - col_off};
      for (int k = 0; k < 8; k++) begin
        p.x     = px[k];
        p.y     = py[k];
        p.color = draw_color;
        p.last  = (k == 7);
        p.done  = (k == 7) && done;
        expected_pixels.push_back(p);
      end
    endfunction

    function void note_request(request_t rq);
      logic signed [DEC_BITS-1:0] diff;
      logic signed [DEC_BITS-1:0] col_wide;
      logic                       done;
      if (rq.req_type == REQ_START) begin
        centre_col = rq.cx;
        centre_row = rq.cy;
        draw_color = rq.color;
        col_off    = '0;
        row_off    = signed'({2'b00, rq.r});
        decision   = DEC_BITS'(3) - (signed'({5'b0, rq.r}) <<< 1);
        active     = 1'b1;
        push_set(1'b0);
      end else if (active) begin
        col_off = col_off + OUT_BITS'(1);
        if (decision > 0) begin
          row_off  = row_off - OUT_BITS'(1);
          diff     = DEC_BITS'(col_off) - DEC_BITS'(row_off);
          decision = decision + (diff <<< 2) + DEC_BITS'(10);
        end else begin
          col_wide = DEC_BITS'(col_off);
          decision = decision + (col_wide <<< 2) + DEC_BITS'(6);
        end
        done = row_off < col_off;
        if (done) active = 1'b0;
        push_set(done);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x) begin
        $error("out_x expected %0d actual %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("out_y expected %0d actual %0d", want.y, got.y);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("out_color expected %06h actual %06h", want.color, got.color);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_set expected %0b actual %0b", want.last, got.last);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("circle_done expected %0b actual %0b", want.done, got.done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   hold_off_cycles = 0;
  int   sent = 0;
  logic tx_burst = 1'b0;

  pixel_scoreboard sb = new;

  mcr_req_if req_if ();
  mcr_pix_if pix_if ();

  midpoint_circle_rasterizer_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .pix (pix_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      sb.note_request('{req_type: req_if.req_type, cx: req_if.center_x,
                        cy: req_if.center_y, r: req_if.radius,
                        color: req_if.pixel_color});
    end
    if (!rst && pix_if.valid && pix_if.ready) begin
      sb.check_pixel('{x: pix_if.out_x, y: pix_if.out_y, color: pix_if.out_color,
                       last: pix_if.last_of_set, done: pix_if.circle_done});
    end
  end

  // pixel receiver with random stalls, bursts and one long hold
  initial begin : pixel_sink
    int   stall;
    int   taken;
    logic rx_burst;
    taken    = 0;
    rx_burst = 1'b0;
    pix_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        pix_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_if.ready <= 1'b1;
      do @(posedge clk); while (!pix_if.valid);
      taken++;
    end
  end

  function automatic int steps_to_close(int r);
    int x;
    int y;
    int d;
    int n;
    x = 0;
    y = r;
    d = 3 - 2 * r;
    n = 0;
    do begin
      x++;
      if (d > 0) begin
        y--;
        d += 4 * (x - y) + 10;
      end else begin
        d += 4 * x + 6;
      end
      n++;
    end while (y >= x);
    return n;
  endfunction

  task automatic send_req(input request_t rq);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rq.req_type;
    req_if.center_x    <= rq.cx;
    req_if.center_y    <= rq.cy;
    req_if.radius      <= rq.r;
    req_if.pixel_color <= rq.color;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  task automatic do_start(input int cx, input int cy, input int r, input int color);
    send_req('{req_type: REQ_START, cx: COORD_BITS'(cx), cy: COORD_BITS'(cy),
               r: COORD_BITS'(r), color: COLOR_BITS'(color)});
  endtask

  task automatic do_step();
    send_req('{req_type: REQ_STEP, cx: COORD_BITS'($urandom), cy: COORD_BITS'($urandom),
               r: COORD_BITS'($urandom), color: COLOR_BITS'($urandom)});
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_circle(input int r);
    do_start($urandom_range(0, 2047), $urandom_range(0, 2047), r,
             $urandom_range(0, 24'hFFFFFF));
  endtask

  initial begin : stimulus
    int  r;
    int  n;
    int  pick;
    int  target;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_START;
    req_if.center_x    <= '0;
    req_if.center_y    <= '0;
    req_if.radius      <= '0;
    req_if.pixel_color <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle step, zero radius, extremes, restart while active
    do_step();
    do_start(0, 0, 0, 0);
    do_step();
    do_step();
    do_start(2047, 2047, 2047, 24'hFFFFFF);
    repeat (3) do_step();
    do_start(0, 2047, 1, 24'h00FF00);
    do_step();
    do_start(1024, 0, 5, 24'hABCDEF);
    repeat (steps_to_close(5)) do_step();
    do_step();
    do_start(2047, 0, 2, 24'h555555);
    repeat (steps_to_close(2)) do_step();
    do_start(0, 0, 2047, 24'hAAAAAA);
    do_step();
    drain();

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 40);
        random_circle(r);
        n = steps_to_close(r);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2);
        repeat (n) do_step();
      end else if (pick < 85) begin
        random_circle($urandom_range(0, 2047));
        repeat ($urandom_range(0, 6)) do_step();
      end else if ($urandom_range(0, 1) == 0) begin
        do_step();
      end else begin
        random_circle($urandom_range(0, 2047));
      end
      if (!hold_done && sent > target - 300) begin
        hold_off_cycles = 400;
        hold_done = 1'b1;
      end
      if (!pause_done && sent > target - 150) begin
        drain();
        pause_done = 1'b1;
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> midpoint_circle_rasterizer_unit.f
rtl/core/mcr_pkg.sv
rtl/core/mcr_if.sv
rtl/core/mcr_sequencer.sv
rtl/core/mcr_datapath.sv
rtl/core/midpoint_circle_rasterizer_unit.sv
tb/tb_top.sv
